// ----- hdl/pcx_rle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_pkg
// Shared types and constants of the PCX run-length palette decoder.
// ----------------------------------------------------------------------------
package pcx_rle_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   localparam logic [7:0] RUN_MARK       = 8'hC0;
   localparam logic [7:0] RUN_COUNT_MASK = 8'h3F;

   localparam logic [15:0] VISIBLE_WIDTH_RST = 16'd640;
   localparam logic [15:0] PADDED_BYTES_RST  = 16'd640;

   localparam logic CMD_PALETTE = 1'b0;
   localparam logic CMD_DATA    = 1'b1;

   localparam logic REG_VISIBLE_WIDTH = 1'b0;
   localparam logic REG_PADDED_BYTES  = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      logic [7:0] index;
      rgb_type    colour;
   } pal_req_type;

   typedef struct packed {
      logic [15:0] visible_width;
      logic [15:0] padded_line_bytes;
   } cfg_type;

endpackage

// ----- hdl/pcx_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_req_if
// Input channel: palette writes and compressed data bytes.
// ----------------------------------------------------------------------------
interface pcx_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;
   logic [7:0] palette_index;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (
      output valid, cmd, data_byte, palette_index, red_in, green_in, blue_in,
      input  ready
   );
   modport sink (
      input  valid, cmd, data_byte, palette_index, red_in, green_in, blue_in,
      output ready
   );
endinterface

// ----- hdl/pcx_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rsp_if
// Result channel: one decoded pixel per beat.
// ----------------------------------------------------------------------------
interface pcx_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_x;
   logic [15:0] pixel_y;
   logic [7:0]  red_out;
   logic [7:0]  green_out;
   logic [7:0]  blue_out;
   logic        last;

   modport source (
      output valid, pixel_x, pixel_y, red_out, green_out, blue_out, last,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, red_out, green_out, blue_out, last,
      output ready
   );
endinterface

// ----- hdl/pcx_rle_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_csr
// APB register file holding the line geometry.
// ----------------------------------------------------------------------------
module pcx_rle_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output pcx_rle_pkg::cfg_type cfg
);

   pcx_rle_pkg::cfg_type cfg_ff, cfg_in;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            pcx_rle_pkg::REG_VISIBLE_WIDTH: cfg_in.visible_width     = csr_pwdata[15:0];
            pcx_rle_pkg::REG_PADDED_BYTES:  cfg_in.padded_line_bytes = csr_pwdata[15:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         pcx_rle_pkg::REG_VISIBLE_WIDTH: csr_prdata = {16'd0, cfg_ff.visible_width};
         pcx_rle_pkg::REG_PADDED_BYTES:  csr_prdata = {16'd0, cfg_ff.padded_line_bytes};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.visible_width     <= pcx_rle_pkg::VISIBLE_WIDTH_RST;
         cfg_ff.padded_line_bytes <= pcx_rle_pkg::PADDED_BYTES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/pcx_rle_palette.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_palette
// Colour store with one write port and a registered read port.
// ----------------------------------------------------------------------------
module pcx_rle_palette (
   input  logic                     clock,
   input  pcx_rle_pkg::pal_req_type pal_req,
   output pcx_rle_pkg::rgb_type     colour
);

   pcx_rle_pkg::rgb_type mem [pcx_rle_pkg::PALETTE_ENTRIES];
   pcx_rle_pkg::rgb_type rd_data_ff;
   logic                 in_range_ff;
   logic                 in_range;

   assign in_range = (int'(pal_req.index) < pcx_rle_pkg::PALETTE_ENTRIES);

   always_ff @(posedge clock) begin
      if (pal_req.wr_en && in_range) begin
         mem[pal_req.index[pcx_rle_pkg::PAL_AW-1:0]] <= pal_req.colour;
      end
   end

   always_ff @(posedge clock) begin
      if (pal_req.rd_en) begin
         rd_data_ff  <= mem[pal_req.index[pcx_rle_pkg::PAL_AW-1:0]];
         in_range_ff <= in_range;
      end
   end

   // out of range lookups read as black
   assign colour = in_range_ff ? rd_data_ff : '0;

endmodule

// ----- hdl/pcx_rle_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_seq
// Run sequencer: one repeat per cycle while the output register has room, through the shared position unit.
// ----------------------------------------------------------------------------
module pcx_rle_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  pcx_rle_pkg::cfg_type      cfg,
   pcx_req_if.sink                   req_bus,
   pcx_rsp_if.source                 rsp_bus,
   output pcx_rle_pkg::pal_req_type  pal_req,
   input  pcx_rle_pkg::rgb_type      colour
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic                 run_pending_ff, run_pending_in;
   logic [5:0]           run_length_ff, run_length_in;
   logic [5:0]           count_ff, count_in;
   logic [15:0]          line_pos_ff, line_pos_in;
   logic [15:0]          row_ff, row_in;
   logic                 out_valid_ff, out_valid_in;
   logic [15:0]          pixel_x_ff, pixel_x_in;
   logic [15:0]          pixel_y_ff, pixel_y_in;
   pcx_rle_pkg::rgb_type rgb_ff, rgb_in;
   logic                 last_ff, last_in;

   logic                 accept;
   logic                 slot_free;
   logic                 emit;
   logic [16:0]          pos_inc;
   logic                 wrap;
   logic                 final_step;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid & req_bus.ready;
   assign slot_free     = ~out_valid_ff | rsp_bus.ready;

   // palette access
   always_comb begin
      pal_req.wr_en        = accept & (req_bus.cmd == pcx_rle_pkg::CMD_PALETTE);
      pal_req.rd_en        = accept & (req_bus.cmd == pcx_rle_pkg::CMD_DATA);
      pal_req.index        = (req_bus.cmd == pcx_rle_pkg::CMD_PALETTE) ?
                             req_bus.palette_index : req_bus.data_byte;
      pal_req.colour.red   = req_bus.red_in;
      pal_req.colour.green = req_bus.green_in;
      pal_req.colour.blue  = req_bus.blue_in;
   end

   // shared position unit
   assign emit       = (line_pos_ff < cfg.visible_width);
   assign pos_inc    = {1'b0, line_pos_ff} + 17'd1;
   assign wrap       = pos_inc[16] | (pos_inc[15:0] >= cfg.padded_line_bytes);
   assign final_step = (count_ff == 6'd1) | wrap;

   always_comb begin
      state_in       = state_ff;
      run_pending_in = run_pending_ff;
      run_length_in  = run_length_ff;
      count_in       = count_ff;
      line_pos_in    = line_pos_ff;
      row_in         = row_ff;
      out_valid_in   = out_valid_ff & ~rsp_bus.ready;
      pixel_x_in     = pixel_x_ff;
      pixel_y_in     = pixel_y_ff;
      rgb_in         = rgb_ff;
      last_in        = last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_bus.cmd == pcx_rle_pkg::CMD_DATA) begin
               if (run_pending_ff) begin
                  run_pending_in = 1'b0;
                  run_length_in  = 6'd0;
                  count_in       = run_length_ff;
                  if (run_length_ff != 6'd0) begin
                     state_in = S_RUN;
                  end
               end else if ((req_bus.data_byte & pcx_rle_pkg::RUN_MARK) ==
                            pcx_rle_pkg::RUN_MARK) begin
                  run_pending_in = 1'b1;
                  run_length_in  = 6'(req_bus.data_byte & pcx_rle_pkg::RUN_COUNT_MASK);
               end else begin
                  count_in = 6'd1;
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            if (slot_free) begin
               if (emit) begin
                  out_valid_in = 1'b1;
                  pixel_x_in   = line_pos_ff;
                  pixel_y_in   = row_ff;
                  rgb_in       = colour;
                  last_in      = final_step | ~(pos_inc[15:0] < cfg.visible_width);
               end
               if (wrap) begin
                  line_pos_in = 16'd0;
                  row_in      = row_ff + 16'd1;
               end else begin
                  line_pos_in = pos_inc[15:0];
               end
               count_in = count_ff - 6'd1;
               if (final_step) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         run_pending_ff <= 1'b0;
         run_length_ff  <= 6'd0;
         count_ff       <= 6'd0;
         line_pos_ff    <= 16'd0;
         row_ff         <= 16'd0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         run_pending_ff <= run_pending_in;
         run_length_ff  <= run_length_in;
         count_ff       <= count_in;
         line_pos_ff    <= line_pos_in;
         row_ff         <= row_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_x_ff <= pixel_x_in;
      pixel_y_ff <= pixel_y_in;
      rgb_ff     <= rgb_in;
      last_ff    <= last_in;
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.pixel_x   = pixel_x_ff;
   assign rsp_bus.pixel_y   = pixel_y_ff;
   assign rsp_bus.red_out   = rgb_ff.red;
   assign rsp_bus.green_out = rgb_ff.green;
   assign rsp_bus.blue_out  = rgb_ff.blue;
   assign rsp_bus.last      = last_ff;

endmodule

// ----- hdl/pcx_rle_palette_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder_core
// PCX 8-bit run-length decoder with palette lookup.
// ----------------------------------------------------------------------------
// A palette write or a run header is taken while the sequencer is idle. A data
// byte is accepted and then its run (1 to 63, cut short at the end of a padded
// line) plays out at one repeat per cycle through a single incrementer; a
// repeat waits while the pixel output register is still full, and no new byte
// is taken until the run ends. A run of zero returns to ready straight away.
// Positions at or beyond the visible width advance the line with no pixel beat.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder_core (
   input  logic        clock,
   input  logic        reset,
   pcx_req_if.sink     req_bus,
   pcx_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   pcx_rle_pkg::cfg_type     cfg;
   pcx_rle_pkg::pal_req_type pal_req;
   pcx_rle_pkg::rgb_type     colour;

   pcx_rle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pcx_rle_palette u_palette (
      .clock   (clock),
      .pal_req (pal_req),
      .colour  (colour)
   );

   pcx_rle_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .pal_req (pal_req),
      .colour  (colour)
   );

endmodule
